// ----- sv/slsg_pkg.sv -----
// slsg_pkg: shared types, constants and the exponential table for the
// sequence log-softmax gather block. No dependencies.
package slsg_pkg;

  localparam int VOCAB_MAX       = 65536;
  localparam int SEQ_MAX         = 4096;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
  localparam int EXP_ROM_W       = 31;

  localparam int VLEN_W = 17;
  localparam int SLEN_W = 13;
  localparam int VPOS_W = 16;
  localparam int RPOS_W = 12;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_VOCAB_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LENGTH = 1'b1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int LOGIT_W = 24;
  localparam int DIFF_W  = 24;
  localparam int TDIFF_W = 25;
  localparam int ESUM_W  = 34;
  localparam int SC_W    = 17;
  localparam int LN_W    = 20;
  localparam int ACC_W   = 40;

  localparam logic [ESUM_W-1:0] ONE_Q16     = 34'd65536;
  localparam logic [ESUM_W-1:0] EXP_SUM_MAX = '1;
  localparam logic [16:0]       LOG2E_Q16   = 17'd94548;
  localparam logic [15:0]       LN2_Q16     = 16'd45426;

  typedef struct packed {
    logic signed [LOGIT_W-1:0] logit;
    logic [15:0]               target_index;
  } slsg_in_t;

  typedef struct packed {
    logic signed [31:0] sequence_logprob;
    logic               target_invalid;
    logic               saturated;
  } slsg_out_t;

  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_LARGER,
    KIND_ADD
  } slsg_kind_t;

  typedef struct packed {
    logic                      row_end;
    logic                      row_ok;
    logic                      seq_end;
    logic signed [TDIFF_W-1:0] tdiff;
  } slsg_info_t;

  typedef struct packed {
    slsg_kind_t        kind;
    logic [DIFF_W-1:0] diff;
    slsg_info_t        info;
  } slsg_item_t;

  typedef struct packed {
    logic [ESUM_W-1:0]         exp_sum;
    logic signed [TDIFF_W-1:0] tdiff;
    logic                      row_ok;
    logic                      seq_end;
  } slsg_row_t;

  typedef logic [EXP_ROM_W-1:0] exp_rom_t [EXP_TABLE_DEPTH];

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bv;
    rem  = n;
    root = '0;
    bv   = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= root + bv) begin
        rem  = rem - (root + bv);
        root = (root >> 1) + bv;
      end else begin
        root = root >> 1;
      end
      bv = bv >> 2;
    end
    return root;
  endfunction

  // 2^-(i/DEPTH) in Q30, product of 2^(-2^-j) roots
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] rc [17];
    logic [63:0] r;
    logic [15:0] f;
    rc[0] = 64'd1 << 29;
    for (int j = 1; j <= 16; j++) rc[j] = isqrt64(rc[j-1] << 30);
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      f = 16'((i * 65536) / EXP_TABLE_DEPTH);
      r = 64'd1 << 30;
      for (int j = 1; j <= 16; j++) begin
        if (f[16-j]) r = (r * rc[j]) >> 30;
      end
      rom[i] = r[EXP_ROM_W-1:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ----- sv/slsg_front.sv -----
// slsg_front: configuration registers, row/sequence counters, running max
// and target capture; classifies each logit for the back end. Uses slsg_pkg.
module slsg_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  slsg_pkg::slsg_in_t               in_data,
  input  logic                             cfg_we,
  input  logic [slsg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slsg_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                             q_push,
  output slsg_pkg::slsg_item_t             q_data,
  input  logic                             q_full
);

  logic [slsg_pkg::VLEN_W-1:0] vocab_size_r;
  logic [slsg_pkg::SLEN_W-1:0] seq_length_r;
  logic [slsg_pkg::VPOS_W-1:0] vpos_r;
  logic [slsg_pkg::RPOS_W-1:0] rpos_r;
  logic [15:0]                 row_target_r;
  logic signed [slsg_pkg::LOGIT_W-1:0] running_max_r;
  logic signed [slsg_pkg::LOGIT_W-1:0] target_logit_r;

  logic [slsg_pkg::VLEN_W-1:0] vlen;
  logic [slsg_pkg::SLEN_W-1:0] slen;
  logic [slsg_pkg::VLEN_W-1:0] vpos_inc;
  logic [slsg_pkg::SLEN_W-1:0] rpos_inc;
  logic                        first;
  logic                        larger;
  logic [15:0]                 tgt;
  logic signed [slsg_pkg::LOGIT_W-1:0] x;
  logic signed [slsg_pkg::LOGIT_W-1:0] rmax_nxt;
  logic signed [slsg_pkg::LOGIT_W-1:0] tl_nxt;
  logic [slsg_pkg::TDIFF_W-1:0] up_diff;
  logic [slsg_pkg::TDIFF_W-1:0] dn_diff;
  logic                        row_end;
  logic                        seq_end;

  assign x = in_data.logit;

  always_comb begin
    if (vocab_size_r == '0) begin
      vlen = slsg_pkg::VLEN_W'(1);
    end else if (vocab_size_r > slsg_pkg::VLEN_W'(slsg_pkg::VOCAB_MAX)) begin
      vlen = slsg_pkg::VLEN_W'(slsg_pkg::VOCAB_MAX);
    end else begin
      vlen = vocab_size_r;
    end
    if (seq_length_r == '0) begin
      slen = slsg_pkg::SLEN_W'(1);
    end else if (seq_length_r > slsg_pkg::SLEN_W'(slsg_pkg::SEQ_MAX)) begin
      slen = slsg_pkg::SLEN_W'(slsg_pkg::SEQ_MAX);
    end else begin
      slen = seq_length_r;
    end
  end

  always_comb begin
    first    = (vpos_r == '0);
    larger   = (x > running_max_r);
    tgt      = first ? in_data.target_index : row_target_r;
    vpos_inc = {1'b0, vpos_r} + slsg_pkg::VLEN_W'(1);
    rpos_inc = {1'b0, rpos_r} + slsg_pkg::SLEN_W'(1);
    row_end  = (vpos_inc >= vlen);
    seq_end  = row_end && (rpos_inc >= slen);
    up_diff  = {x[slsg_pkg::LOGIT_W-1], x}
             - {running_max_r[slsg_pkg::LOGIT_W-1], running_max_r};
    dn_diff  = {running_max_r[slsg_pkg::LOGIT_W-1], running_max_r}
             - {x[slsg_pkg::LOGIT_W-1], x};
    rmax_nxt = (first || larger) ? x : running_max_r;
    tl_nxt   = first ? '0 : target_logit_r;
    if (tgt == vpos_r) tl_nxt = x;

    q_data.info.row_end = row_end;
    q_data.info.row_ok  = ({1'b0, tgt} < vlen);
    q_data.info.seq_end = seq_end;
    q_data.info.tdiff   = {tl_nxt[slsg_pkg::LOGIT_W-1], tl_nxt}
                        - {rmax_nxt[slsg_pkg::LOGIT_W-1], rmax_nxt};
    if (first) begin
      q_data.kind = slsg_pkg::KIND_FIRST;
      q_data.diff = '0;
    end else if (larger) begin
      q_data.kind = slsg_pkg::KIND_LARGER;
      q_data.diff = up_diff[slsg_pkg::DIFF_W-1:0];
    end else begin
      q_data.kind = slsg_pkg::KIND_ADD;
      q_data.diff = dn_diff[slsg_pkg::DIFF_W-1:0];
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vocab_size_r <= slsg_pkg::VLEN_W'(slsg_pkg::VOCAB_MAX);
      seq_length_r <= slsg_pkg::SLEN_W'(slsg_pkg::SEQ_MAX);
      vpos_r       <= '0;
      rpos_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          slsg_pkg::CFG_VOCAB_SIZE: vocab_size_r <= cfg_wdata;
          slsg_pkg::CFG_SEQ_LENGTH: seq_length_r <= cfg_wdata[slsg_pkg::SLEN_W-1:0];
        endcase
      end
      if (q_push) begin
        vpos_r <= row_end ? '0 : vpos_inc[slsg_pkg::VPOS_W-1:0];
        if (row_end) rpos_r <= seq_end ? '0 : rpos_inc[slsg_pkg::RPOS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      row_target_r   <= tgt;
      running_max_r  <= rmax_nxt;
      target_logit_r <= tl_nxt;
    end
  end

endmodule

// ----- sv/slsg_queue.sv -----
// slsg_queue: short register queue of classified logits between the front
// and the exponential pipeline. Uses slsg_pkg.
module slsg_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  slsg_pkg::slsg_item_t push_data,
  output logic                 full,
  output logic                 pop_valid,
  output slsg_pkg::slsg_item_t pop_data,
  input  logic                 pop
);

  slsg_pkg::slsg_item_t                mem_r [slsg_pkg::QUEUE_DEPTH];
  logic [slsg_pkg::QUEUE_PTR_W-1:0]    wr_ptr_r;
  logic [slsg_pkg::QUEUE_PTR_W-1:0]    rd_ptr_r;
  logic [slsg_pkg::QUEUE_CNT_W-1:0]    count_r;
  logic [slsg_pkg::QUEUE_CNT_W-1:0]    count_nxt;

  assign full      = (count_r == slsg_pkg::QUEUE_CNT_W'(slsg_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + slsg_pkg::QUEUE_CNT_W'(1);
    if (pop && !push) count_nxt = count_r - slsg_pkg::QUEUE_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + slsg_pkg::QUEUE_PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + slsg_pkg::QUEUE_PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= slsg_pkg::QUEUE_CNT_W'(slsg_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue popped while empty");

endmodule

// ----- sv/slsg_exp.sv -----
// slsg_exp: three-stage table exponential and the rescaled exponential sum;
// hands each finished row to the log unit. Uses slsg_pkg.
module slsg_exp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  slsg_pkg::slsg_item_t q_data,
  output logic                 q_pop,
  output logic                 row_valid,
  output slsg_pkg::slsg_row_t  row_data,
  input  logic                 row_ready
);

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3, adv3;

  slsg_pkg::slsg_kind_t kind1_r, kind2_r, kind3_r;
  slsg_pkg::slsg_info_t info1_r, info2_r, info3_r;
  logic [24:0]                      y1_r;
  logic [slsg_pkg::EXP_ROM_W-1:0]   rom2_r;
  logic [4:0]                       sh2_r;
  logic                             big2_r;
  logic [slsg_pkg::SC_W-1:0]        sc3_r;
  logic [slsg_pkg::ESUM_W-1:0]      es_r;

  logic [40:0]                      prod1;
  logic [8:0]                       k1;
  logic [slsg_pkg::EXP_IDX_W-1:0]   idx1;
  logic [31:0]                      rsum2;
  logic [31:0]                      sc2;
  logic [50:0]                      prod3;
  logic [50:0]                      round3;
  logic [35:0]                      big3;
  logic [slsg_pkg::ESUM_W-1:0]      es_nxt;

  assign adv3  = v3_r && (!info3_r.row_end || row_ready);
  assign en3   = !v3_r || adv3;
  assign en2   = !v2_r || en3;
  assign en1   = !v1_r || en2;
  assign q_pop = q_valid && en1;

  // y = a * log2(e) in Q16, split into integer shift and table index
  always_comb begin
    prod1 = 41'(q_data.diff) * 41'(slsg_pkg::LOG2E_Q16);
    k1    = y1_r[24:16];
    idx1  = y1_r[15 -: slsg_pkg::EXP_IDX_W];
    rsum2 = {1'b0, rom2_r} + (32'd1 << (sh2_r - 5'd1));
    sc2   = big2_r ? '0 : (rsum2 >> sh2_r);
  end

  always_comb begin
    prod3  = 51'(es_r) * 51'(sc3_r);
    round3 = (prod3 + 51'(32768)) >> 16;
    unique case (kind3_r)
      slsg_pkg::KIND_FIRST:  big3 = 36'(slsg_pkg::ONE_Q16);
      slsg_pkg::KIND_LARGER: big3 = round3[35:0] + 36'(slsg_pkg::ONE_Q16);
      slsg_pkg::KIND_ADD:    big3 = 36'(es_r) + 36'(sc3_r);
      default:               big3 = 36'(es_r);
    endcase
    es_nxt = (big3 > 36'(slsg_pkg::EXP_SUM_MAX)) ? slsg_pkg::EXP_SUM_MAX
                                                   : big3[slsg_pkg::ESUM_W-1:0];
  end

  assign row_valid        = v3_r && info3_r.row_end;
  assign row_data.exp_sum = es_nxt;
  assign row_data.tdiff   = info3_r.tdiff;
  assign row_data.row_ok  = info3_r.row_ok;
  assign row_data.seq_end = info3_r.seq_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= q_pop;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      kind1_r <= q_data.kind;
      info1_r <= q_data.info;
      y1_r    <= prod1[40:16];
    end
    if (en2) begin
      kind2_r <= kind1_r;
      info2_r <= info1_r;
      rom2_r  <= slsg_pkg::EXP_ROM[idx1];
      sh2_r   <= 5'(k1) + 5'd14;
      big2_r  <= (k1 >= 9'd17);
    end
    if (en3) begin
      kind3_r <= kind2_r;
      info3_r <= info2_r;
      sc3_r   <= sc2[slsg_pkg::SC_W-1:0];
    end
    if (adv3) es_r <= es_nxt;
  end

  a_sum_floor: assert property (@(posedge clk) disable iff (!rst_n)
    adv3 |=> es_r >= slsg_pkg::ONE_Q16)
    else $error("exponential sum below one after update");

endmodule

// ----- sv/slsg_log.sv -----
// slsg_log: iterative natural log of the row sum, row term accumulation and
// the sequence result register. Uses slsg_pkg.
module slsg_log (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                row_valid,
  input  slsg_pkg::slsg_row_t row_data,
  output logic                row_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output slsg_pkg::slsg_out_t out_data
);

  typedef enum logic [2:0] {
    L_IDLE,
    L_LEAD,
    L_NORM,
    L_SQ,
    L_LN,
    L_ACC
  } lstate_t;

  lstate_t                             state_r, state_nxt;
  logic [slsg_pkg::ESUM_W-1:0]         s_r, s_nxt;
  logic signed [slsg_pkg::TDIFF_W-1:0] tdiff_r, tdiff_nxt;
  logic                                row_ok_r, row_ok_nxt;
  logic                                seq_end_r, seq_end_nxt;
  logic [5:0]                          p_r, p_nxt;
  logic [30:0]                         r_r, r_nxt;
  logic [15:0]                         frac_r, frac_nxt;
  logic [3:0]                          cnt_r, cnt_nxt;
  logic [slsg_pkg::LN_W-1:0]           ln_r, ln_nxt;
  logic signed [slsg_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic                                bad_r, bad_nxt;
  logic                                out_valid_r, out_valid_nxt;
  slsg_pkg::slsg_out_t                 out_data_r, out_data_nxt;

  logic [5:0]                          lead;
  logic [61:0]                         sq;
  logic [20:0]                         lg;
  logic [36:0]                         lnp;
  logic signed [26:0]                  term;
  logic signed [40:0]                  acc_sum;
  logic signed [slsg_pkg::ACC_W-1:0]   acc_new;
  logic                                bad_new;
  logic                                out_free;
  logic                                clamp;

  assign row_ready = (state_r == L_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    lead = '0;
    for (int i = 0; i < slsg_pkg::ESUM_W; i++) begin
      if (s_r[i]) lead = 6'(i);
    end
    sq   = 62'(r_r) * 62'(r_r);
    lg   = {5'(p_r - 6'd16), frac_r};
    lnp  = 37'(lg) * 37'(slsg_pkg::LN2_Q16) + 37'(32768);
    term = {{2{tdiff_r[slsg_pkg::TDIFF_W-1]}}, tdiff_r} - 27'(ln_r);
    acc_sum = {{14{term[26]}}, term} + {acc_r[slsg_pkg::ACC_W-1], acc_r};
    if (!row_ok_r) begin
      acc_new = acc_r;
    end else if (acc_sum[40] != acc_sum[39]) begin
      acc_new = acc_sum[40] ? {1'b1, {(slsg_pkg::ACC_W-1){1'b0}}}
                            : {1'b0, {(slsg_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_new = acc_sum[slsg_pkg::ACC_W-1:0];
    end
    bad_new = bad_r || !row_ok_r;
    // clamped when the bits above the 32-bit range are not a sign extension
    clamp = !((&acc_new[slsg_pkg::ACC_W-1:31]) || !(|acc_new[slsg_pkg::ACC_W-1:31]));
  end

  always_comb begin
    state_nxt     = state_r;
    s_nxt         = s_r;
    tdiff_nxt     = tdiff_r;
    row_ok_nxt    = row_ok_r;
    seq_end_nxt   = seq_end_r;
    p_nxt         = p_r;
    r_nxt         = r_r;
    frac_nxt      = frac_r;
    cnt_nxt       = cnt_r;
    ln_nxt        = ln_r;
    acc_nxt       = acc_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      L_IDLE: begin
        if (row_valid) begin
          s_nxt       = (row_data.exp_sum < slsg_pkg::ONE_Q16) ? slsg_pkg::ONE_Q16
                                                              : row_data.exp_sum;
          tdiff_nxt   = row_data.tdiff;
          row_ok_nxt  = row_data.row_ok;
          seq_end_nxt = row_data.seq_end;
          state_nxt   = L_LEAD;
        end
      end
      L_LEAD: begin
        p_nxt     = lead;
        state_nxt = L_NORM;
      end
      L_NORM: begin
        // mantissa with its leading one at bit 30
        if (p_r <= 6'd30) begin
          r_nxt = 31'(s_r << (6'd30 - p_r));
        end else begin
          r_nxt = 31'(s_r >> (p_r - 6'd30));
        end
        frac_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = L_SQ;
      end
      L_SQ: begin
        if (sq[61]) begin
          r_nxt    = sq[61:31];
          frac_nxt = {frac_r[14:0], 1'b1};
        end else begin
          r_nxt    = sq[60:30];
          frac_nxt = {frac_r[14:0], 1'b0};
        end
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == '1) state_nxt = L_LN;
      end
      L_LN: begin
        ln_nxt    = lnp[16 +: slsg_pkg::LN_W];
        state_nxt = L_ACC;
      end
      L_ACC: begin
        if (!seq_end_r) begin
          acc_nxt   = acc_new;
          bad_nxt   = bad_new;
          state_nxt = L_IDLE;
        end else if (out_free) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.target_invalid   = bad_new;
          out_data_nxt.saturated        = clamp;
          if (!clamp) begin
            out_data_nxt.sequence_logprob = acc_new[31:0];
          end else if (acc_new[slsg_pkg::ACC_W-1]) begin
            out_data_nxt.sequence_logprob = 32'sh8000_0000;
          end else begin
            out_data_nxt.sequence_logprob = 32'sh7FFF_FFFF;
          end
          acc_nxt   = '0;
          bad_nxt   = 1'b0;
          state_nxt = L_IDLE;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= L_IDLE;
      acc_r       <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s_r        <= s_nxt;
    tdiff_r    <= tdiff_nxt;
    row_ok_r   <= row_ok_nxt;
    seq_end_r  <= seq_end_nxt;
    p_r        <= p_nxt;
    r_r        <= r_nxt;
    frac_r     <= frac_nxt;
    cnt_r      <= cnt_nxt;
    ln_r       <= ln_nxt;
    out_data_r <= out_data_nxt;
  end

  a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == L_SQ |-> r_r[30])
    else $error("log mantissa not normalized during squaring");

  a_lead_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == L_LN |-> (p_r >= 6'd16 && p_r <= 6'd33))
    else $error("log exponent out of range");

endmodule

// ----- sv/sequence_log_softmax_gather.sv -----
// sequence_log_softmax_gather: top level, front classifier, queue,
// exponential pipeline and log unit. Uses slsg_pkg and the slsg_* modules.
//
// Usage: logits stream in on in_* (valid/stall), one row of vocab_size
// logits per position, seq_length rows per sequence, each with the row's
// target index (taken from the row's first logit). One transaction leaves
// on out_* (valid/stall) per sequence with the summed target
// log-probability in Q16.16 and the invalid-target and clamp flags.
// cfg_we/cfg_index/cfg_wdata write vocab_size (index 0) and seq_length
// (index 1); write only while the block is idle.
// Throughput: one logit per cycle while in_stall is low and the log unit
// finishes each row before the next row ends; the log unit works on one
// row at a time (leading-one search, normalize, 16 squaring steps, scale,
// accumulate), so shorter rows are limited by it. A stalled result holds
// in the output register while the block keeps taking logits, until the
// queue and pipeline fill and in_stall rises. Reset sets both lengths to
// their maximum and clears the row, sequence and accumulator state.
module sequence_log_softmax_gather (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  slsg_pkg::slsg_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output slsg_pkg::slsg_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [slsg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slsg_pkg::CFG_W-1:0]     cfg_wdata
);

  logic                 q_push;
  slsg_pkg::slsg_item_t q_wdata;
  logic                 q_full;
  logic                 q_valid;
  slsg_pkg::slsg_item_t q_rdata;
  logic                 q_pop;
  logic                 row_valid;
  slsg_pkg::slsg_row_t  row_data;
  logic                 row_ready;

  slsg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_data    (q_wdata),
    .q_full    (q_full)
  );

  slsg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_data  (q_rdata),
    .pop       (q_pop)
  );

  slsg_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .row_valid (row_valid),
    .row_data  (row_data),
    .row_ready (row_ready)
  );

  slsg_log u_log (
    .clk       (clk),
    .rst_n     (rst_n),
    .row_valid (row_valid),
    .row_data  (row_data),
    .row_ready (row_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
